FILE: hdl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clk edge outside reset.
`define ASSERT_IMPLIES(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain condition that must hold at every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

FILE: hdl/dmx_pkg.sv
// Shared constants, codes and controller/datapath interface types for the downmix unit.
package dmx_pkg;

  localparam int MAX_CHANNELS = 8;

  localparam int SAMPLE_W  = 32;
  localparam int FMT_W     = 3;
  localparam int CNT_W     = 4;
  localparam int POS_W     = 3;
  localparam int SUM_W     = 35;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;

  // Radix-16 divider by the channel count: 4 quotient bits per step.
  localparam int DIV_RADIX = 4;
  localparam int DIV_W     = 36;
  localparam int DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W = 4;
  localparam int REM_W     = CNT_W - 1;

  // Sample format codes
  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_PCM16   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_PCM24   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_PCM32   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_UNKNOWN = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FMT_CODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

  typedef struct packed {
    logic capture;   // latch the incoming word
    logic decode;    // normalize the latched word to Q1.31
    logic accum;     // add into the frame sum, advance channel position
    logic div_load;  // start the average, clear the frame
    logic div_step;  // one radix-16 divide step
    logic out_load;  // write the result register
  } dmx_cmd_t;

  typedef struct packed {
    logic last;      // the word being accumulated closes the frame
    logic div_last;  // current divide step is the final one
    logic out_busy;  // result register full and not taken this cycle
  } dmx_stat_t;

endpackage

FILE: hdl/interleaved_downmix_to_mono_unit.sv
// Top level of the interleaved multichannel to mono downmix unit.
//
//  port group | dir | word contents (lowest bit first)
//  -----------+-----+-------------------------------------------
//  s_axis     | in  | tdata: sample_bits[31:0]; tuser: silent
//  m_axis     | out | tdata: mono_sample[31:0] (signed Q1.31)
//  cfg        | in  | idx 0 fmt_code[2:0], idx 1 channel_count[3:0]
//
// A word that does not close a frame passes through accept, decode and accumulate.
// A word that closes a frame passes through those, the divider load, 9 radix-16
// divide steps (the divider sets this figure) and the result write.
// The result register holds one finished sample; the next word is accepted
// while it waits, and only a second frame end stalls until it is taken.
// rst is synchronous: format unknown, 2 channels, frame state cleared.
module interleaved_downmix_to_mono_unit
  import dmx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [31:0] sample_bits
  input  logic                 s_axis_tuser,   // [0] silent
  // Output words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [31:0] mono_sample
  // Config writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dmx_cmd_t  cmd;
  dmx_stat_t stat;

  // Sequencer: one word in flight at a time.
  dmx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Decode, accumulate, average, hold result.
  dmx_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (s_axis_tdata),
    .in_silent (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata)
  );

  // Checks
  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "two datapath commands at once")
  `ASSERT_IMPLIES(a_accept_decodes, (s_axis_tvalid && s_axis_tready) |=> cmd.decode, "no decode")
  `ASSERT_IMPLIES(a_no_overwrite, cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready), "overwrite")
  `ASSERT_IMPLIES(a_load_shows, cmd.out_load |=> m_axis_tvalid, "loaded result not presented")

endmodule

FILE: hdl/dmx_div.sv
// Iterative unsigned divider by a small divisor, four quotient bits per cycle while step is asserted.
module dmx_div
  import dmx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 step,
  input  logic [SUM_W-1:0]     dividend,
  input  logic [CNT_W-1:0]     divisor,
  output logic [DIV_W-1:0]     quotient,
  output logic                 last_step
);

  logic [DIV_W-1:0]     sh;
  logic [REM_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;

  logic [REM_W-1:0]     rem_next;
  logic [DIV_RADIX-1:0] qbits;

  // Remainder stays below the divisor (at most 8), so each partial value is 4 bits.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [CNT_W-1:0] part;
    r     = rem;
    qbits = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      part = {r, sh[DIV_W-1-i]};
      if (part >= dvs) begin
        r                       = REM_W'(part - dvs);
        qbits[DIV_RADIX-1-i]    = 1'b1;
      end else begin
        r = part[REM_W-1:0];
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh  <= DIV_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (step) begin
      sh  <= {sh[DIV_W-DIV_RADIX-1:0], qbits};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + DIV_CNT_W'(1);
    end
  end

  assign quotient  = sh;
  assign last_step = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

FILE: hdl/dmx_datapath.sv
// Datapath: config registers, sample decode, frame accumulator, divider and result register.
module dmx_datapath
  import dmx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dmx_cmd_t              cmd,
  output dmx_stat_t             stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [SAMPLE_W-1:0]   in_word,
  input  logic                  in_silent,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_word
);

  localparam logic [SAMPLE_W-1:0] Q31_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] Q31_MIN = 32'h8000_0000;

  logic [FMT_W-1:0]    fmt_code;
  logic [CNT_W-1:0]    channel_count;
  logic [CNT_W-1:0]    eff_count;

  logic [SAMPLE_W-1:0] word;
  logic                word_silent;
  logic [SAMPLE_W-1:0] q;
  logic                q_mark;
  logic [SAMPLE_W-1:0] q_next;
  logic                q_mark_next;

  logic [POS_W-1:0]    channel_position;
  logic [SUM_W-1:0]    frame_sum;
  logic                frame_silent;

  logic [SUM_W-1:0]    sum_mag;
  logic                res_neg;
  logic                res_zero;
  logic [DIV_W-1:0]    quotient;
  logic                div_last;
  logic [SAMPLE_W-1:0] result;

  // IEEE single to Q1.31: scale by 2^31, truncate toward zero, saturate, NaN to zero.
  function automatic logic [SAMPLE_W-1:0] float_to_q31(input logic [SAMPLE_W-1:0] w);
    logic                neg;
    logic [7:0]          e;
    logic [23:0]         m;
    logic [7:0]          rs;
    logic [SAMPLE_W-1:0] mag;
    logic                sat;
    logic [SAMPLE_W-1:0] res;
    neg = w[31];
    e   = w[30:23];
    m   = {1'b0, w[22:0]};
    mag = '0;
    sat = 1'b0;
    rs  = '0;
    if (e == 8'd255) begin
      if (w[22:0] != '0) res = '0;
      else               res = neg ? Q31_MIN : Q31_MAX;
    end else begin
      if (e == 8'd0) e = 8'd1;
      else           m[23] = 1'b1;
      if (e >= 8'd127) begin
        sat = 1'b1;
      end else if (e >= 8'd119) begin
        mag = {8'b0, m} << (e - 8'd119);
      end else begin
        rs = 8'd119 - e;
        if (rs >= 8'd32) mag = '0;
        else             mag = {8'b0, m} >> rs[4:0];
      end
      if (sat) res = neg ? Q31_MIN : Q31_MAX;
      else     res = neg ? (~mag + SAMPLE_W'(1)) : mag;
    end
    return res;
  endfunction

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_code      <= FMT_UNKNOWN;
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FMT_CODE:      fmt_code      <= cfg_data[FMT_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (channel_count == '0)                          eff_count = CNT_W'(1);
    else if (channel_count > CNT_W'(MAX_CHANNELS))    eff_count = CNT_W'(MAX_CHANNELS);
    else                                              eff_count = channel_count;
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word        <= in_word;
      word_silent <= in_silent;
    end
  end

  // Decode
  always_comb begin
    q_mark_next = 1'b0;
    unique case (fmt_code)
      FMT_FLOAT32: q_next = float_to_q31(word);
      FMT_PCM16:   q_next = {word[15:0], 16'b0};
      FMT_PCM24:   q_next = {word[23:0], 8'b0};
      FMT_PCM32:   q_next = word;
      default: begin
        q_next      = '0;
        q_mark_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      q      <= q_next;
      q_mark <= q_mark_next | word_silent;
    end
  end

  // Frame state
  assign stat.last = ((CNT_W'(channel_position) + CNT_W'(1)) >= eff_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_position <= '0;
      frame_sum        <= '0;
      frame_silent     <= 1'b0;
    end else if (cmd.accum) begin
      frame_sum        <= frame_sum + {{(SUM_W-SAMPLE_W){q[SAMPLE_W-1]}}, q};
      frame_silent     <= frame_silent | q_mark;
      channel_position <= stat.last ? '0 : channel_position + POS_W'(1);
    end else if (cmd.div_load) begin
      frame_sum    <= '0;
      frame_silent <= 1'b0;
    end
  end

  assign sum_mag = frame_sum[SUM_W-1] ? (~frame_sum + SUM_W'(1)) : frame_sum;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      res_neg  <= frame_sum[SUM_W-1];
      res_zero <= frame_silent;
    end
  end

  dmx_div u_div (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.div_load),
    .step      (cmd.div_step),
    .dividend  (sum_mag),
    .divisor   (eff_count),
    .quotient  (quotient),
    .last_step (div_last)
  );

  assign stat.div_last = div_last;

  assign result = res_zero ? '0
                : res_neg  ? (~quotient[SAMPLE_W-1:0] + SAMPLE_W'(1))
                :            quotient[SAMPLE_W-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_word <= result;
  end

  assign stat.out_busy = out_valid & ~out_ready;

endmodule

FILE: hdl/dmx_ctrl.sv
// Controller state machine sequencing capture, decode, accumulate, divide and output.
module dmx_ctrl
  import dmx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dmx_stat_t stat,
  output dmx_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_ACC  = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } dmx_state_t;

  dmx_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = stat.last ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: bench/mono_average_checker.sv
// Checker for the downmix unit: predicts each frame average and compares it with the output words.
`timescale 1ns / 1ps

module mono_average_checker
  import dmx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [31:0]          in_bits,
  input  logic                 in_silent,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [31:0]          out_sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   pending_count
);

  logic [FMT_W-1:0] fmt_code;
  logic [CNT_W-1:0] channel_count;
  int unsigned      position;
  longint           frame_total;
  logic             frame_zeroed;
  logic [31:0]      expected_mono[$];
  int               errors = 0;

  // Raw word to Q1.31 under the given format; unknown formats give zero.
  function automatic logic [31:0] decode_to_q31(input logic [FMT_W-1:0] fmt,
                                                input logic [31:0] w);
    logic            neg;
    int              e;
    int              sh;
    longint unsigned m;
    longint unsigned mag;
    neg = w[31];
    e   = int'(w[30:23]);
    m   = w[22:0];
    case (fmt)
      FMT_PCM16: return {w[15:0], 16'h0};
      FMT_PCM24: return {w[23:0], 8'h0};
      FMT_PCM32: return w;
      FMT_FLOAT32: begin
        if (e == 255) begin
          if (m != 0) return '0;  // NaN
          mag = 64'h8000_0000;
        end else begin
          if (e == 0) e = 1;      // denormal
          else m = m | 64'h80_0000;
          sh = e - 119;
          if (sh >= 8) mag = 64'h8000_0000;
          else if (sh >= 0) mag = m << sh;
          else if (sh <= -32) mag = 0;
          else mag = m >> (-sh);
        end
        if (mag >= 64'h8000_0000) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (neg) mag = -mag;
        return mag[31:0];
      end
      default: return '0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [31:0] q;
    logic [31:0] want;
    int unsigned eff;
    if (rst) begin
      fmt_code      = FMT_UNKNOWN;
      channel_count = CHANNEL_COUNT_RESET;
      position      = 0;
      frame_total   = 0;
      frame_zeroed  = 1'b0;
      expected_mono.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_mono.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected mono word %h", out_sample);
        end else begin
          want = expected_mono.pop_front();
          if (out_sample !== want) begin
            errors++;
            if (errors <= 10)
              $display("mono_sample mismatch: expected %h (%0d) got %h (%0d)",
                       want, $signed(want), out_sample, $signed(out_sample));
          end
        end
      end

      if (in_valid && in_ready) begin
        eff = (channel_count == 0) ? 1 :
              (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : channel_count;
        q = decode_to_q31(fmt_code, in_bits);
        if (fmt_code >= FMT_UNKNOWN || in_silent) frame_zeroed = 1'b1;
        frame_total += longint'($signed(q));
        if (position + 1 >= eff) begin
          expected_mono.push_back(frame_zeroed ? 32'h0 : 32'(frame_total / longint'(eff)));
          position     = 0;
          frame_total  = 0;
          frame_zeroed = 1'b0;
        end else begin
          position++;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_FMT_CODE:      fmt_code      = cfg_data[FMT_W-1:0];
          REG_CHANNEL_COUNT: channel_count = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count  <= expected_mono.size();
    mismatch_count <= errors;
  end

endmodule

FILE: bench/interleaved_downmix_to_mono_unit_test.sv
// Top of the downmix unit testbench: clock, reset, stimulus, stall control and verdict.
`timescale 1ns / 1ps

module interleaved_downmix_to_mono_unit_test;
  import dmx_pkg::*;

  // Formats past FMT_UNKNOWN are also unknown; named here so phases can use them.
  localparam logic [FMT_W-1:0] FMT_SPARE_5 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_SPARE_6 = 3'd6;
  localparam logic [FMT_W-1:0] FMT_SPARE_7 = 3'd7;

  // Margin for the last frame-closing word to finish before registers are touched.
  localparam int SETTLE_CYCLES   = 24;
  localparam int STUCK_LIMIT     = 4000;
  localparam int PHASES          = 14;
  localparam int WORDS_PER_PHASE = 32;

  // Per-phase settings. Counts hit 1 and 8 plus the clamped values 0 and 15 and 9.
  localparam logic [FMT_W-1:0] PHASE_FMT [PHASES] = '{
    FMT_FLOAT32, FMT_PCM16, FMT_PCM24, FMT_PCM32, FMT_UNKNOWN, FMT_FLOAT32, FMT_PCM16,
    FMT_PCM24, FMT_PCM32, FMT_SPARE_5, FMT_FLOAT32, FMT_SPARE_6, FMT_PCM32, FMT_SPARE_7};
  localparam logic [CNT_W-1:0] PHASE_CNT [PHASES] = '{
    4'd1, 4'd8, 4'd2, 4'd3, 4'd2, 4'd0, 4'd15, 4'd4, 4'd8, 4'd7, 4'd6, 4'd5, 4'd8, 4'd9};

  // Full-scale and sign-boundary words for the fixed-point formats
  localparam logic [31:0] CORNER_WORDS [8] = '{
    32'h0000_7FFF, 32'hFFFF_8000, 32'h007F_FFFF, 32'hFF80_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // [31:0] sample_bits
  logic                 s_axis_tuser = 1'b0; // [0] silent
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // [31:0] mono_sample
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FMT_CODE;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int pending_count;
  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;       // chance per cycle that the receiver drops tready
  int stuck_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interleaved_downmix_to_mono_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mono_average_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_bits       (s_axis_tdata),
    .in_silent     (s_axis_tuser),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_sample    (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // Receiver: random backpressure at the current stall rate, redrawn every cycle.
  always @(posedge clk) begin
    m_axis_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  // Watchdog: too long without a word moving on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one input word, with random hold-off first; returns at the edge that takes it.
  // tready is looked at on the falling edge, where nothing is in motion.
  task automatic send_word(input logic [31:0] bits, input logic quiet);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    s_axis_tuser  <= quiet;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  // Drop the input, wait for every predicted word, then for the tail of any open frame.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only once the unit has gone quiet.
  task automatic load_settings(input logic [CFG_W-1:0] fmt, input logic [CFG_W-1:0] cnt);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FMT_CODE;
    cfg_data  <= fmt;
    @(posedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [31:0] w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-channel frames so each word shows its own decode.
    load_settings(CFG_W'(FMT_PCM32), 4'd1);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b1);   // silent flag zeroes the frame

    load_settings(CFG_W'(FMT_PCM16), 4'd1);
    send_word(32'h0000_7FFF, 1'b0);
    send_word(32'hFFFF_8000, 1'b0);   // upper half must be ignored

    load_settings(CFG_W'(FMT_PCM24), 4'd1);
    send_word(32'h007F_FFFF, 1'b0);
    send_word(32'hAB80_0000, 1'b0);   // top byte must be ignored

    load_settings(CFG_W'(FMT_FLOAT32), 4'd1);
    send_word(32'h3F80_0000, 1'b0);   // +1.0 saturates high
    send_word(32'hBF80_0000, 1'b0);   // -1.0 is exactly full scale negative
    send_word(32'h7FC0_0000, 1'b0);   // NaN decodes to zero
    send_word(32'hFF80_0000, 1'b0);   // -inf
    send_word(32'h7F80_0000, 1'b0);   // +inf
    send_word(32'h0000_0001, 1'b0);   // denormal
    send_word(32'h3F00_0000, 1'b0);   // 0.5
    send_word(32'hBEFF_FFFF, 1'b0);   // just above -0.5 (magnitude just under 0.5), truncation toward zero

    // Unknown formats zero the frame no matter what the words hold
    load_settings(CFG_W'(FMT_UNKNOWN), 4'd2);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    load_settings(CFG_W'(FMT_SPARE_7), 4'd1);
    send_word(32'h4000_0000, 1'b0);

    // Random phases. Phase length is not a multiple of every channel count, so some frames
    // straddle the register writes and exercise count and format changes mid-frame.
    for (int p = 0; p < PHASES; p++) begin
      load_settings(CFG_W'(PHASE_FMT[p]), PHASE_CNT[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        w = $urandom;
        if (PHASE_FMT[p] == FMT_FLOAT32) begin
          // Mostly magnitudes below one, some specials and some raw noise
          case ($urandom_range(7))
            0: ;
            1: w[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            default: w[30:23] = 8'($urandom_range(105, 130));
          endcase
        end else if ($urandom_range(7) == 0) begin
          w = CORNER_WORDS[$urandom_range(7)];
        end
        send_word(w, $urandom_range(15) == 0);
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
